FILE: rtl/olid_pkg.sv
// Shared types and constants for the ordered list unit.
// Used by the front, the back and the top level; depends on nothing.
`timescale 1ns / 1ps

package olid_pkg;

	localparam int DATA_W     = 32;
	localparam int CMDQ_DEPTH = 2;
	localparam int OUT_DEPTH  = 4;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_DELETE     = 2'd2,
		OP_NOP        = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// What the back has to carry out once the front has checked the word
	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_DELETE     = 2'd2,
		CMD_NONE       = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		status_t            status;
		logic [DATA_W-1:0]  operand;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic                     is_last;
		logic                     list_empty;
		status_t                  status;
	} result_t;

endpackage

FILE: rtl/olid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module olid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/olid_front.sv
// Front end: accepts input words, checks them against a shadow element count
// and queues classified commands for the back. Depends on olid_pkg.
`timescale 1ns / 1ps

module olid_front
	import olid_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] value_or_index,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  logic                     cmd_take
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int QPW = $clog2(CMDQ_DEPTH);
	localparam int QCW = $clog2(CMDQ_DEPTH + 1);

	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_next;
	cmd_t           cls;
	cmd_t           queue_q [CMDQ_DEPTH];
	logic [QPW-1:0] wp_q;
	logic [QPW-1:0] rp_q;
	logic [QCW-1:0] qcnt_q;
	logic           accept;
	logic           take;
	opcode_t        op;

	assign op        = opcode_t'(opcode);
	assign full      = (qcnt_q == QCW'(CMDQ_DEPTH));
	assign accept    = push && !full;
	assign cmd_valid = (qcnt_q != '0);
	assign cmd       = queue_q[rp_q];
	assign take      = cmd_take && cmd_valid;

	// Classify against the count the list will hold once earlier commands are done
	always_comb begin
		cls.operand = $unsigned(value_or_index);
		cls.kind    = CMD_NONE;
		cls.status  = ST_OK;
		count_next  = count_q;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (count_q >= CW'(CAPACITY)) begin
					cls.status = ST_FULL;
				end else begin
					cls.kind   = (op == OP_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
					count_next = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				// negative index is huge as unsigned, so it always fails here
				if ($unsigned(value_or_index) >= DATA_W'(count_q)) begin
					cls.status = ST_RANGE;
				end else begin
					cls.kind   = CMD_DELETE;
					count_next = count_q - CW'(1);
				end
			end
			default: begin
				cls.kind = CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wp_q    <= '0;
			rp_q    <= '0;
			qcnt_q  <= '0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				wp_q    <= (wp_q == QPW'(CMDQ_DEPTH - 1)) ? '0 : wp_q + QPW'(1);
			end
			if (take) begin
				rp_q <= (rp_q == QPW'(CMDQ_DEPTH - 1)) ? '0 : rp_q + QPW'(1);
			end
			qcnt_q <= qcnt_q + QCW'(accept) - QCW'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wp_q] <= cls;
		end
	end

	a_qcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QCW'(CMDQ_DEPTH))
		else $error("command queue over capacity");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("shadow count past capacity");

	a_full_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> cmd_valid)
		else $error("full raised with no command waiting");

endmodule

FILE: rtl/olid_back.sv
// Back end: carries out queued commands on the circular element store, shifts
// on delete and streams the list into a small result queue. Depends on olid_pkg, olid_ram.
`timescale 1ns / 1ps

module olid_back
	import olid_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_take,
	output logic    res_valid,
	output result_t res,
	input  logic    res_pop
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int PW  = $clog2(CAPACITY);
	localparam int SW  = CW + 1;
	localparam int OPW = $clog2(OUT_DEPTH);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_SHIFT_WB,
		S_EMIT
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   fp_q;
	logic [CW-1:0]   k_q;
	logic            wr_pend_q;
	logic [PW-1:0]   wr_addr_q;
	logic            rd_vld_s1;
	logic            last_s1;
	logic            empty_s1;
	status_t         status_s1;

	result_t         ofifo_q [OUT_DEPTH];
	logic [OPW-1:0]  owp_q;
	logic [OPW-1:0]  orp_q;
	logic [OCW-1:0]  ocnt_q;

	logic            ram_we;
	logic [PW-1:0]   ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [PW-1:0]   ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic [PW-1:0]   fp_dec;
	logic [CW-1:0]   del_idx;
	logic            can_issue;
	logic            emit_last;
	logic            opop;
	result_t         s1_res;

	function automatic logic [PW-1:0] slot_of(input logic [CW-1:0] k,
		input logic [PW-1:0] fp);
		logic [SW-1:0] s;
		s = SW'(fp) + SW'(k);
		if (s >= SW'(CAPACITY)) begin
			s = s - SW'(CAPACITY);
		end
		return s[PW-1:0];
	endfunction

	olid_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign fp_dec    = (fp_q == '0) ? PW'(CAPACITY - 1) : fp_q - PW'(1);
	assign del_idx   = cmd.operand[CW-1:0];
	assign cmd_take  = (state_q == S_IDLE);
	assign ram_raddr = slot_of(k_q, fp_q);
	assign can_issue = (ocnt_q + OCW'(rd_vld_s1)) < OCW'(OUT_DEPTH);
	assign emit_last = (count_q == '0) || ((k_q + CW'(1)) == count_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		if (wr_pend_q) begin
			// shift write: the word read last cycle moves one place to the front
			ram_we    = 1'b1;
			ram_waddr = wr_addr_q;
			ram_wdata = ram_rdata;
		end else if (state_q == S_IDLE && cmd_valid) begin
			case (cmd.kind)
				CMD_PUSH_FRONT: begin
					ram_we    = 1'b1;
					ram_waddr = fp_dec;
					ram_wdata = cmd.operand;
				end
				CMD_PUSH_BACK: begin
					ram_we    = 1'b1;
					ram_waddr = slot_of(count_q, fp_q);
					ram_wdata = cmd.operand;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			fp_q      <= '0;
			k_q       <= '0;
			wr_pend_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			wr_pend_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						k_q     <= '0;
						state_q <= S_EMIT;
						case (cmd.kind)
							CMD_PUSH_FRONT: begin
								fp_q    <= fp_dec;
								count_q <= count_q + CW'(1);
							end
							CMD_PUSH_BACK: begin
								count_q <= count_q + CW'(1);
							end
							CMD_DELETE: begin
								if ((del_idx + CW'(1)) == count_q) begin
									count_q <= count_q - CW'(1);
								end else begin
									k_q     <= del_idx + CW'(1);
									state_q <= S_SHIFT;
								end
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_SHIFT: begin
					wr_pend_q <= 1'b1;
					wr_addr_q <= slot_of(k_q - CW'(1), fp_q);
					k_q       <= k_q + CW'(1);
					if ((k_q + CW'(1)) == count_q) begin
						state_q <= S_SHIFT_WB;
					end
				end
				S_SHIFT_WB: begin
					count_q <= count_q - CW'(1);
					k_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (can_issue) begin
						rd_vld_s1 <= 1'b1;
						last_s1   <= emit_last;
						empty_s1  <= (count_q == '0);
						status_s1 <= cmd_q.status;
						k_q       <= k_q + CW'(1);
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
	end

	// Result queue
	assign s1_res.element    = empty_s1 ? '0 : $signed(ram_rdata);
	assign s1_res.is_last    = last_s1;
	assign s1_res.list_empty = empty_s1;
	assign s1_res.status     = status_s1;
	assign res_valid         = (ocnt_q != '0);
	assign res               = ofifo_q[orp_q];
	assign opop              = res_pop && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (rd_vld_s1) begin
				owp_q <= (owp_q == OPW'(OUT_DEPTH - 1)) ? '0 : owp_q + OPW'(1);
			end
			if (opop) begin
				orp_q <= (orp_q == OPW'(OUT_DEPTH - 1)) ? '0 : orp_q + OPW'(1);
			end
			ocnt_q <= ocnt_q + OCW'(rd_vld_s1) - OCW'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			ofifo_q[owp_q] <= s1_res;
		end
	end

	a_ofifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= OCW'(OUT_DEPTH))
		else $error("result queue over capacity");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> k_q < count_q)
		else $error("shift read past list end");

	a_wr_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_q |-> (state_q == S_SHIFT || state_q == S_SHIFT_WB))
		else $error("shift write outside shift");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count past capacity");

endmodule

FILE: rtl/ordered_list_insert_delete_unit.sv
// Ordered list unit: deque of signed words with delete by index.
// Both channels behave as queues. Input: drive opcode and value_or_index with
// push; the word is taken on a clock edge with push high and full low.
// Results: while empty is low the oldest result sits on element, is_last,
// list_empty and status; pop on a clock edge with empty low takes it.
// Every input word yields the whole list front to back, is_last on the final
// word; an empty list yields one word with list_empty set and element zero.
// A front stage checks each word and queues it (two entries); a back stage
// updates the circular store in a single-port-write RAM and streams the list.
// In the back, a delete at an index short of the last element first moves
// later elements one slot forward before the list is streamed.
// Reset clears the list and both queues; store contents need no clearing.
// When pop is held low the four-entry result queue fills, the back holds,
// the command queue fills and full rises; nothing is lost.
// Depends on olid_pkg, olid_front, olid_back, olid_ram.
`timescale 1ns / 1ps

module ordered_list_insert_delete_unit
	import olid_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] value_or_index,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DATA_W-1:0] element,
	output logic                     is_last,
	output logic                     list_empty,
	output logic [1:0]               status
);

	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_take;
	logic    res_valid;
	result_t res;

	olid_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.value_or_index (value_or_index),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_take       (cmd_take)
	);

	olid_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop)
	);

	assign empty      = !res_valid;
	assign element    = res.element;
	assign is_last    = res.is_last;
	assign list_empty = res.list_empty;
	assign status     = res.status;

endmodule

FILE: test/olid_list_checker.sv
`timescale 1ns / 1ps
// Checker for the ordered list unit: mirrors the list on every accepted input
// word and compares each popped result word with the oldest prediction.
// Depends on olid_pkg for the opcode, status and result types.

module olid_list_checker
	import olid_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     full,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] value_or_index,
	input  logic                     empty,
	input  logic                     pop,
	input  logic signed [DATA_W-1:0] element,
	input  logic                     is_last,
	input  logic                     list_empty,
	input  logic [1:0]               status,
	output int                       fail_count,
	output int                       pending,
	output int                       list_size,
	output int                       words_in,
	output int                       words_out,
	output int                       full_drops,
	output int                       range_flags
);

	logic signed [DATA_W-1:0] list_q[$];
	result_t                  expected_q[$];

	// Apply one input word to the mirrored list and queue the words it yields
	function automatic void predict_list(input opcode_t op, input logic signed [DATA_W-1:0] arg);
		status_t st;
		result_t r;
		st = ST_OK;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (list_q.size() >= CAPACITY)
					st = ST_FULL;
				else if (op == OP_PUSH_FRONT)
					list_q.push_front(arg);
				else
					list_q.push_back(arg);
			end
			OP_DELETE: begin
				if (arg < 0 || arg >= list_q.size())
					st = ST_RANGE;
				else
					list_q.delete(arg);
			end
			default: ;
		endcase
		if (st == ST_FULL)
			full_drops++;
		if (st == ST_RANGE)
			range_flags++;
		words_in++;
		if (list_q.size() == 0) begin
			r.element    = '0;
			r.is_last    = 1'b1;
			r.list_empty = 1'b1;
			r.status     = st;
			expected_q.push_back(r);
		end else begin
			foreach (list_q[k]) begin
				r.element    = list_q[k];
				r.is_last    = (k == list_q.size() - 1);
				r.list_empty = 1'b0;
				r.status     = st;
				expected_q.push_back(r);
			end
		end
	endfunction

	function automatic void compare_word();
		result_t want;
		words_out++;
		if (expected_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result word with nothing expected: element %0d last %0b empty %0b status %0d",
					$time, element, is_last, list_empty, status);
			return;
		end
		want = expected_q.pop_front();
		if (element !== want.element || is_last !== want.is_last ||
				list_empty !== want.list_empty || status !== want.status) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: mismatch: expected element %0d last %0b empty %0b status %0d, got element %0d last %0b empty %0b status %0d",
					$time, want.element, want.is_last, want.list_empty, want.status,
					element, is_last, list_empty, status);
		end
	endfunction

	initial begin
		fail_count  = 0;
		words_in    = 0;
		words_out   = 0;
		full_drops  = 0;
		range_flags = 0;
		pending     = 0;
		list_size   = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_q.delete();
			expected_q.delete();
			pending   <= 0;
			list_size <= 0;
		end else begin
			if (push && !full)
				predict_list(opcode_t'(opcode), value_or_index);
			if (pop && !empty)
				compare_word();
			// publish after the edge so the driver never races the update
			pending   <= expected_q.size();
			list_size <= list_q.size();
		end
	end

endmodule

FILE: test/tb_ordered_list_insert_delete_unit.sv
`timescale 1ns / 1ps
// Testbench top for the ordered list unit: drives directed and random words
// under three idling mixes and gives the verdict from olid_list_checker.
// Depends on olid_pkg, olid_list_checker and the unit itself.

module tb_ordered_list_insert_delete_unit;
	import olid_pkg::*;

	localparam int CAPACITY    = 32;
	localparam int STALL_LIMIT = 3000;
	localparam int RAND_WORDS  = 100;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     push           = 1'b0;
	logic [1:0]               opcode         = OP_NOP;
	logic signed [DATA_W-1:0] value_or_index = '0;
	logic                     pop            = 1'b0;
	logic                     full;
	logic                     empty;
	logic signed [DATA_W-1:0] element;
	logic                     is_last;
	logic                     list_empty;
	logic [1:0]               status;

	int fail_count, pending, list_size, words_in, words_out, full_drops, range_flags;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles   = 0;

	always #4 clk = ~clk;

	ordered_list_insert_delete_unit #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.value_or_index(value_or_index),
		.empty(empty),
		.pop(pop),
		.element(element),
		.is_last(is_last),
		.list_empty(list_empty),
		.status(status)
	);

	olid_list_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.value_or_index(value_or_index),
		.empty(empty),
		.pop(pop),
		.element(element),
		.is_last(is_last),
		.list_empty(list_empty),
		.status(status),
		.fail_count(fail_count),
		.pending(pending),
		.list_size(list_size),
		.words_in(words_in),
		.words_out(words_out),
		.full_drops(full_drops),
		.range_flags(range_flags)
	);

	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles", STALL_LIMIT);
				$display("ordered_list_insert_delete_unit verification failed");
				$finish;
			end
		end
	end

	// Hold push high across back-to-back words; drop it only to idle
	task automatic send_word(input opcode_t op, input logic signed [DATA_W-1:0] arg);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push           <= 1'b1;
		opcode         <= op;
		value_or_index <= arg;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic send_random(input bit grow);
		int                       r;
		int                       n;
		opcode_t                  op;
		logic signed [DATA_W-1:0] arg;
		r = $urandom_range(0, 99);
		n = list_size;
		if (r < (grow ? 90 : 10)) begin
			op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			case ($urandom_range(0, 15))
				0:       arg = 32'sh8000_0000;
				1:       arg = 32'sh7FFF_FFFF;
				2:       arg = '0;
				3:       arg = -1;
				default: arg = $urandom;
			endcase
		end else if (r < 97) begin
			op = OP_DELETE;
			case ($urandom_range(0, 9))
				7:       arg = n;
				8:       arg = {1'b1, 31'($urandom)};
				9:       arg = $urandom;
				default: arg = (n > 0) ? $urandom_range(0, n - 1) : 0;
			endcase
		end else begin
			op  = OP_NOP;
			arg = $urandom;
		end
		send_word(op, arg);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 45;

		// empty list: no change, deletes out of range
		send_word(OP_NOP, 32'sd7);
		send_word(OP_DELETE, 32'sd0);
		send_word(OP_DELETE, -32'sd1);
		// extremes at both ends
		send_word(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_word(OP_PUSH_BACK, 32'sh8000_0000);
		send_word(OP_PUSH_FRONT, 32'sd0);
		send_word(OP_PUSH_BACK, -32'sd1);
		send_word(OP_PUSH_BACK, 32'sd1);
		send_word(OP_NOP, 32'sh8000_0000);
		// negative index and index at the count
		send_word(OP_DELETE, -32'sd1);
		send_word(OP_DELETE, 32'sh8000_0000);
		send_word(OP_DELETE, 32'sd5);
		send_word(OP_DELETE, 32'sh7FFF_FFFF);
		// last, first, middle, then drain to empty
		send_word(OP_DELETE, 32'sd4);
		send_word(OP_DELETE, 32'sd0);
		send_word(OP_DELETE, 32'sd1);
		send_word(OP_DELETE, 32'sd0);
		send_word(OP_DELETE, 32'sd0);
		send_word(OP_DELETE, 32'sd0);
		send_word(OP_PUSH_BACK, 32'sh5555_5555);
		send_word(OP_PUSH_FRONT, 32'shAAAA_AAAA);

		// each phase grows the list into overflow, then drains it
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 45 : 0;
			recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 20 : 0;
			for (int i = 0; i < RAND_WORDS; i++)
				send_random(i < RAND_WORDS / 2);
		end

		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d input words and checked %0d result words under three idling mixes;",
			words_in, words_out);
		$display("%0d pushes hit a full list and %0d deletes were out of range.",
			full_drops, range_flags);
		if (fail_count == 0 && pending == 0)
			$display("ordered_list_insert_delete_unit verification clean");
		else
			$display("ordered_list_insert_delete_unit verification failed");
		$finish;
	end

endmodule
